// ===== rtl/lpi_pkg.sv =====
// ----------------------------------------------------------------------------
// Line pair intersection package
// Shared widths, result codes, register indices and the divider state types.
// ----------------------------------------------------------------------------
package lpi_pkg;

  localparam int FracBits = 16;
  localparam int DataW    = 32;
  localparam int MagW     = 63;                  // product difference magnitude
  localparam int NumW     = MagW + FracBits;     // shifted dividend width
  localparam int QuoW     = 41;                  // kept quotient bits
  localparam int CfgW     = 31;

  localparam logic [1:0] KindNone  = 2'd0;
  localparam logic [1:0] KindOnce  = 2'd1;
  localparam logic [1:0] KindCoinc = 2'd2;

  localparam logic CfgIdxTol  = 1'b0;
  localparam logic CfgIdxZero = 1'b1;

  // State carried along the divider chain for one quotient.
  typedef struct packed {
    logic            neg;
    logic            zero_num;
    logic            zero_den;
    logic            ovf;
    logic [MagW:0]   rem;
    logic [NumW-1:0] num;
    logic [MagW-1:0] den;
    logic [QuoW-1:0] quo;
  } div_t;

  // Per-item control carried alongside the dividers.
  typedef struct packed {
    logic       va;
    logic       vb;
    logic [CfgW-1:0] tol;
  } ctl_t;

endpackage

// ===== rtl/lpi_div_cell.sv =====
// ----------------------------------------------------------------------------
// Division cell
// One registered restoring-division step; a chain of these forms a divider.
// ----------------------------------------------------------------------------
module lpi_div_cell (
  input  logic          clk,
  input  lpi_pkg::div_t d_in,
  output lpi_pkg::div_t d_out
);

  lpi_pkg::div_t       d_nxt;
  logic [lpi_pkg::MagW:0] trial;
  logic                one;

  // Shift in the next dividend bit and try a subtraction.
  always_comb begin
    d_nxt = d_in;
    trial = {d_in.rem[lpi_pkg::MagW-1:0], d_in.num[lpi_pkg::NumW-1]};
    one   = trial >= {1'b0, d_in.den};
    d_nxt.rem = one ? (trial - {1'b0, d_in.den}) : trial;
    d_nxt.num = {d_in.num[lpi_pkg::NumW-2:0], 1'b0};
    if (d_in.quo[lpi_pkg::QuoW-1]) begin
      d_nxt.ovf = 1'b1;
    end else begin
      d_nxt.quo = {d_in.quo[lpi_pkg::QuoW-2:0], one};
    end
  end

  always_ff @(posedge clk) begin
    d_out <= d_nxt;
  end

endmodule

// ===== rtl/lpi_divider.sv =====
// ----------------------------------------------------------------------------
// Pipelined divider
// A row of division cells giving a saturated signed fixed-point quotient.
// ----------------------------------------------------------------------------
module lpi_divider (
  input  logic                          clk,
  input  logic                          neg,
  input  logic [lpi_pkg::MagW-1:0]      num,
  input  logic [lpi_pkg::MagW-1:0]      den,
  output logic signed [lpi_pkg::DataW-1:0] quo,
  output logic                          sat
);

  lpi_pkg::div_t chain [0:lpi_pkg::NumW];
  logic [lpi_pkg::QuoW-1:0] limit;
  lpi_pkg::div_t last;

  // Load the head of the chain with the dividend shifted left by FracBits.
  always_comb begin
    chain[0].neg      = neg;
    chain[0].zero_num = num == '0;
    chain[0].zero_den = den == '0;
    chain[0].ovf      = 1'b0;
    chain[0].rem      = '0;
    chain[0].num      = {num, {lpi_pkg::FracBits{1'b0}}};
    chain[0].den      = den;
    chain[0].quo      = '0;
  end

  for (genvar i = 0; i < lpi_pkg::NumW; i++) begin : g_cell
    lpi_div_cell u_cell (.clk(clk), .d_in(chain[i]), .d_out(chain[i+1]));
  end

  // Saturate and apply the sign.
  always_comb begin
    last  = chain[lpi_pkg::NumW];
    limit = last.neg ? lpi_pkg::QuoW'(33'h080000000) : lpi_pkg::QuoW'(32'h7FFFFFFF);
    sat   = 1'b0;
    quo   = '0;
    if (last.zero_num) begin
      quo = '0;
    end else if (last.zero_den || last.ovf || last.quo > limit) begin
      sat = 1'b1;
      quo = last.neg ? -lpi_pkg::DataW'(limit) : lpi_pkg::DataW'(limit);
    end else begin
      quo = last.neg ? -lpi_pkg::DataW'(last.quo) : lpi_pkg::DataW'(last.quo);
    end
  end

endmodule

// ===== rtl/line_pair_intersection.sv =====
// ----------------------------------------------------------------------------
// Line pair intersection
// Classifies two lines p*x+q*y=r and gives their meeting point by Cramer's rule.
// ----------------------------------------------------------------------------
// Channel   Direction  Transfer
// in_*      input      start high and busy low at a rising edge
// out_*     output     out_valid high for one cycle
// cfg_*     input      cfg_we high at a rising edge
// One item may be accepted every cycle; busy is always low.
// out_valid rises once the accepted item has passed the operand register, the
// product register, 79 division cells (all eight dividers side by side) and the
// output register.
// Reset clears the valid pipeline and restores the register defaults.
// The receiver cannot stall; each result is shown for exactly one cycle.
module line_pair_intersection (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic signed [lpi_pkg::DataW-1:0]  in_p_a,
  input  logic signed [lpi_pkg::DataW-1:0]  in_q_a,
  input  logic signed [lpi_pkg::DataW-1:0]  in_r_a,
  input  logic signed [lpi_pkg::DataW-1:0]  in_p_b,
  input  logic signed [lpi_pkg::DataW-1:0]  in_q_b,
  input  logic signed [lpi_pkg::DataW-1:0]  in_r_b,
  input  logic                              cfg_we,
  input  logic                              cfg_index,
  input  logic [lpi_pkg::CfgW-1:0]          cfg_data,
  output logic                              out_valid,
  output logic [1:0]                        out_meet_kind,
  output logic signed [lpi_pkg::DataW-1:0]  out_point_x,
  output logic signed [lpi_pkg::DataW-1:0]  out_point_y,
  output logic                              out_saturated
);

  localparam int Lat = lpi_pkg::NumW;

  logic [lpi_pkg::CfgW-1:0] tol_r;
  logic [15:0]              zth_r;
  logic                     acc;

  assign busy = 1'b0;
  assign acc  = start;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r <= lpi_pkg::CfgW'(7);
      zth_r <= 16'd1;
    end else if (cfg_we) begin
      if (cfg_index == lpi_pkg::CfgIdxTol) begin
        tol_r <= cfg_data;
      end else begin
        zth_r <= cfg_data[15:0];
      end
    end
  end

  function automatic logic [31:0] mag(input logic [31:0] v);
    begin
      mag = v[31] ? (~v + 32'd1) : v;
    end
  endfunction

  // Stage 1: operand magnitudes and signs, vertical tests.
  logic                 v1_r;
  logic [31:0]          pa_r, qa_r, ra_r, pb_r, qb_r, rb_r;
  logic [31:0]          mpa_r, mqa_r, mra_r, mpb_r, mqb_r, mrb_r;
  lpi_pkg::ctl_t        c1_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= acc;
    end
  end
  always_ff @(posedge clk) begin
    pa_r <= in_p_a; qa_r <= in_q_a; ra_r <= in_r_a;
    pb_r <= in_p_b; qb_r <= in_q_b; rb_r <= in_r_b;
    mpa_r <= mag(in_p_a); mqa_r <= mag(in_q_a); mra_r <= mag(in_r_a);
    mpb_r <= mag(in_p_b); mqb_r <= mag(in_q_b); mrb_r <= mag(in_r_b);
    c1_r.va  <= mag(in_q_a) <= {16'd0, zth_r};
    c1_r.vb  <= mag(in_q_b) <= {16'd0, zth_r};
    c1_r.tol <= tol_r;
  end

  // Stage 2: the six products.
  logic [63:0] m_paqb_r, m_pbqa_r, m_raqb_r, m_rbqa_r, m_parb_r, m_pbra_r;
  logic        s_paqb_r, s_pbqa_r, s_raqb_r, s_rbqa_r, s_parb_r, s_pbra_r;
  logic        v2_r;
  lpi_pkg::ctl_t c2_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else begin
      v2_r <= v1_r;
    end
  end
  always_ff @(posedge clk) begin
    m_paqb_r <= mpa_r * mqb_r; s_paqb_r <= pa_r[31] ^ qb_r[31];
    m_pbqa_r <= mpb_r * mqa_r; s_pbqa_r <= pb_r[31] ^ qa_r[31];
    m_raqb_r <= mra_r * mqb_r; s_raqb_r <= ra_r[31] ^ qb_r[31];
    m_rbqa_r <= mrb_r * mqa_r; s_rbqa_r <= rb_r[31] ^ qa_r[31];
    m_parb_r <= mpa_r * mrb_r; s_parb_r <= pa_r[31] ^ rb_r[31];
    m_pbra_r <= mpb_r * mra_r; s_pbra_r <= pb_r[31] ^ ra_r[31];
    c2_r <= c1_r;
  end

  // Signed-magnitude difference a - b of two products.
  function automatic logic [63:0] smd(input logic an, input logic [63:0] am,
                                       input logic bn, input logic [63:0] bm);
    logic a_n, b_n;
    logic [63:0] r;
    logic rn;
    begin
      a_n = (am != '0) & an;
      b_n = (bm != '0) & ~bn;
      if (a_n == b_n) begin
        rn = a_n; r = am + bm;
      end else if (am >= bm) begin
        rn = a_n; r = am - bm;
      end else begin
        rn = b_n; r = bm - am;
      end
      if (r == '0) rn = 1'b0;
      smd = {rn, r[62:0]};
    end
  endfunction

  logic [63:0] det_w, xn_w, yn_w;
  assign det_w = smd(s_paqb_r, m_paqb_r, s_pbqa_r, m_pbqa_r);
  assign xn_w  = smd(s_raqb_r, m_raqb_r, s_rbqa_r, m_rbqa_r);
  assign yn_w  = smd(s_parb_r, m_parb_r, s_pbra_r, m_pbra_r);

  // Slope and offset quotients, from the stage-1 magnitudes (delayed one stage).
  logic [31:0] mpa2_r, mqa2_r, mra2_r, mpb2_r, mqb2_r, mrb2_r;
  logic        spa_r, sqa_r, sra_r, spb_r, sqb_r, srb_r;
  always_ff @(posedge clk) begin
    mpa2_r <= mpa_r; mqa2_r <= mqa_r; mra2_r <= mra_r;
    mpb2_r <= mpb_r; mqb2_r <= mqb_r; mrb2_r <= mrb_r;
    spa_r <= pa_r[31]; sqa_r <= qa_r[31]; sra_r <= ra_r[31];
    spb_r <= pb_r[31]; sqb_r <= qb_r[31]; srb_r <= rb_r[31];
  end

  logic signed [31:0] sl_a, sl_b, oq_a, oq_b, op_a, op_b, qx, qy;
  logic sat_sla, sat_slb, sat_oqa, sat_oqb, sat_opa, sat_opb, sat_x, sat_y;

  lpi_divider u_sla (.clk(clk), .neg(~(spa_r ^ sqa_r)), .num(63'(mpa2_r)),
                     .den(63'(mqa2_r)), .quo(sl_a), .sat(sat_sla));
  lpi_divider u_slb (.clk(clk), .neg(~(spb_r ^ sqb_r)), .num(63'(mpb2_r)),
                     .den(63'(mqb2_r)), .quo(sl_b), .sat(sat_slb));
  lpi_divider u_oqa (.clk(clk), .neg(sra_r ^ sqa_r), .num(63'(mra2_r)),
                     .den(63'(mqa2_r)), .quo(oq_a), .sat(sat_oqa));
  lpi_divider u_oqb (.clk(clk), .neg(srb_r ^ sqb_r), .num(63'(mrb2_r)),
                     .den(63'(mqb2_r)), .quo(oq_b), .sat(sat_oqb));
  lpi_divider u_opa (.clk(clk), .neg(sra_r ^ spa_r), .num(63'(mra2_r)),
                     .den(63'(mpa2_r)), .quo(op_a), .sat(sat_opa));
  lpi_divider u_opb (.clk(clk), .neg(srb_r ^ spb_r), .num(63'(mrb2_r)),
                     .den(63'(mpb2_r)), .quo(op_b), .sat(sat_opb));
  lpi_divider u_x (.clk(clk), .neg(xn_w[63] ^ det_w[63]), .num(xn_w[62:0]),
                   .den(det_w[62:0]), .quo(qx), .sat(sat_x));
  lpi_divider u_y (.clk(clk), .neg(yn_w[63] ^ det_w[63]), .num(yn_w[62:0]),
                   .den(det_w[62:0]), .quo(qy), .sat(sat_y));

  // Control delay line matching the dividers.
  logic          vd_r [0:Lat-1];
  lpi_pkg::ctl_t cd_r [0:Lat-1];
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < Lat; i++) vd_r[i] <= 1'b0;
    end else begin
      vd_r[0] <= v2_r;
      for (int i = 1; i < Lat; i++) vd_r[i] <= vd_r[i-1];
    end
  end
  always_ff @(posedge clk) begin
    cd_r[0] <= c2_r;
    for (int i = 1; i < Lat; i++) cd_r[i] <= cd_r[i-1];
  end

  // Classification on the quotients.
  lpi_pkg::ctl_t c;
  logic [32:0]   d_sl, d_off, a_sl, a_off;
  logic          once, coinc;
  logic signed [31:0] oa, ob;
  always_comb begin
    c     = cd_r[Lat-1];
    d_sl  = {sl_a[31], sl_a} - {sl_b[31], sl_b};
    a_sl  = d_sl[32] ? -d_sl : d_sl;
    oa    = (c.va && c.vb) ? op_a : oq_a;
    ob    = (c.va && c.vb) ? op_b : oq_b;
    d_off = {oa[31], oa} - {ob[31], ob};
    a_off = d_off[32] ? -d_off : d_off;
    if (c.va && c.vb) begin
      once = 1'b0;
    end else if (c.va || c.vb) begin
      once = 1'b1;
    end else begin
      once = a_sl > {2'b00, c.tol};
    end
    coinc = a_off < {2'b00, c.tol};
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= vd_r[Lat-1];
    end
  end
  always_ff @(posedge clk) begin
    if (once) begin
      out_meet_kind <= lpi_pkg::KindOnce;
      out_point_x   <= qx;
      out_point_y   <= qy;
      out_saturated <= sat_x | sat_y;
    end else begin
      out_meet_kind <= coinc ? lpi_pkg::KindCoinc : lpi_pkg::KindNone;
      out_point_x   <= '0;
      out_point_y   <= '0;
      out_saturated <= 1'b0;
    end
  end

endmodule

// ===== rtl/lpi_checker.sv =====
// ----------------------------------------------------------------------------
// Line pair intersection checker
// Port-level properties of the top level, bound to it.
// ----------------------------------------------------------------------------
module lpi_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        busy,
  input logic        out_valid,
  input logic [1:0]  out_meet_kind,
  input logic [31:0] out_point_x,
  input logic [31:0] out_point_y,
  input logic        out_saturated
);

  a_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_meet_kind == lpi_pkg::KindNone || out_meet_kind == lpi_pkg::KindOnce ||
                   out_meet_kind == lpi_pkg::KindCoinc))
    else $error("illegal meeting kind");

  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_meet_kind != lpi_pkg::KindOnce) |->
      (out_point_x == '0 && out_point_y == '0))
    else $error("point not zero without a single meeting");

  a_sat: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_saturated) |-> (out_meet_kind == lpi_pkg::KindOnce))
    else $error("saturation without a single meeting");

  a_busy: assert property (@(posedge clk) !busy)
    else $error("busy raised");

  a_rst: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result after reset");

endmodule

bind line_pair_intersection lpi_checker u_lpi_checker (.*);

// ===== dv/tb_line_pair_intersection.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Line pair intersection testbench
// Sends line pairs through the command port with random gaps and checks every
// result against a bit-exact predictor of the classification and Cramer
// quotients. It is run under several tolerance and zero-threshold settings.
// ----------------------------------------------------------------------------
module tb_line_pair_intersection;

  typedef struct {
    logic signed [lpi_pkg::DataW-1:0] pa, qa, ra, pb, qb, rb;
  } line_pair_t;

  typedef struct {
    logic [1:0]                       kind;
    logic signed [lpi_pkg::DataW-1:0] x;
    logic signed [lpi_pkg::DataW-1:0] y;
    logic                             sat;
  } meeting_t;

  localparam int WatchdogLimit = 5000;

  logic                             clk = 1'b0;
  logic                             rst_n = 1'b0;
  logic                             start = 1'b0;
  logic                             busy;
  logic signed [lpi_pkg::DataW-1:0] in_p_a = '0, in_q_a = '0, in_r_a = '0;
  logic signed [lpi_pkg::DataW-1:0] in_p_b = '0, in_q_b = '0, in_r_b = '0;
  logic                             cfg_we = 1'b0;
  logic                             cfg_index = 1'b0;
  logic [lpi_pkg::CfgW-1:0]         cfg_data = '0;
  logic                             out_valid;
  logic [1:0]                       out_meet_kind;
  logic signed [lpi_pkg::DataW-1:0] out_point_x, out_point_y;
  logic                             out_saturated;

  line_pair_t pair_q[$];
  meeting_t   meeting_q[$];
  line_pair_t cur_pair;
  logic [30:0] tol_cfg = 31'd7;
  logic [15:0] zero_cfg = 16'd1;
  int          gap_left = 0;
  bit          burst_mode = 1'b0;
  int          error_count = 0;
  int          quiet_cycles = 0;

  line_pair_intersection dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_p_a(in_p_a), .in_q_a(in_q_a), .in_r_a(in_r_a),
    .in_p_b(in_p_b), .in_q_b(in_q_b), .in_r_b(in_r_b),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .out_valid(out_valid), .out_meet_kind(out_meet_kind),
    .out_point_x(out_point_x), .out_point_y(out_point_y),
    .out_saturated(out_saturated)
  );

  // Clock: 4 ns period.
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Magnitude of a 32-bit signed coefficient.
  function automatic logic [63:0] coef_mag(logic signed [lpi_pkg::DataW-1:0] v);
    logic signed [33:0] e;
    e = v;
    if (e < 0) e = -e;
    return 64'(e);
  endfunction

  // Fixed-point quotient (num << FracBits) / den, truncated and clamped.
  function automatic longint fx_quotient(bit neg, logic [63:0] num, logic [63:0] den,
                                         output bit sat);
    logic [127:0] qq;
    logic [63:0]  lim;
    lim = neg ? 64'h8000_0000 : 64'h7FFF_FFFF;
    sat = 1'b0;
    if (num == 0) return 0;
    if (den == 0) begin
      sat = 1'b1;
      return neg ? -longint'(lim) : longint'(lim);
    end
    qq = ({64'b0, num} << lpi_pkg::FracBits) / {64'b0, den};
    if (qq > {64'b0, lim}) begin
      sat = 1'b1;
      qq = {64'b0, lim};
    end
    return neg ? -longint'(qq[63:0]) : longint'(qq[63:0]);
  endfunction

  // Signed ratio a/b of two coefficients, optionally negated.
  function automatic longint coef_ratio(logic signed [lpi_pkg::DataW-1:0] a,
                                        logic signed [lpi_pkg::DataW-1:0] b, bit negate);
    bit s;
    return fx_quotient((a[31] != b[31]) ^ negate, coef_mag(a), coef_mag(b), s);
  endfunction

  // Exact a*b - c*d as sign and magnitude.
  function automatic void cross_diff(logic signed [lpi_pkg::DataW-1:0] a,
                                     logic signed [lpi_pkg::DataW-1:0] b,
                                     logic signed [lpi_pkg::DataW-1:0] c,
                                     logic signed [lpi_pkg::DataW-1:0] d,
                                     output bit neg, output logic [63:0] m);
    logic signed [65:0] ea, eb, ec, ed, t;
    ea = a; eb = b; ec = c; ed = d;
    t = ea * eb - ec * ed;
    neg = t < 0;
    if (neg) t = -t;
    m = t[63:0];
  endfunction

  function automatic longint abs_diff(longint a, longint b);
    return (a > b) ? a - b : b - a;
  endfunction

  // Expected meeting of one line pair under the current register settings.
  function automatic meeting_t predict_meeting(line_pair_t lp);
    meeting_t    m;
    bit          va, vb, once, dn, xn, yn, sx, sy;
    logic [63:0] dm, xm, ym;
    longint      oa, ob;
    va = coef_mag(lp.qa) <= zero_cfg;
    vb = coef_mag(lp.qb) <= zero_cfg;
    if (va && vb) once = 1'b0;
    else if (va || vb) once = 1'b1;
    else once = abs_diff(coef_ratio(lp.pa, lp.qa, 1'b1),
                         coef_ratio(lp.pb, lp.qb, 1'b1)) > longint'(tol_cfg);
    m.x = '0;
    m.y = '0;
    m.sat = 1'b0;
    if (once) begin
      m.kind = lpi_pkg::KindOnce;
      cross_diff(lp.pa, lp.qb, lp.pb, lp.qa, dn, dm);
      cross_diff(lp.ra, lp.qb, lp.rb, lp.qa, xn, xm);
      cross_diff(lp.pa, lp.rb, lp.pb, lp.ra, yn, ym);
      m.x = 32'(fx_quotient(xn != dn, xm, dm, sx));
      m.y = 32'(fx_quotient(yn != dn, ym, dm, sy));
      m.sat = sx || sy;
    end else begin
      if (va && vb) begin
        oa = coef_ratio(lp.ra, lp.pa, 1'b0);
        ob = coef_ratio(lp.rb, lp.pb, 1'b0);
      end else begin
        oa = coef_ratio(lp.ra, lp.qa, 1'b0);
        ob = coef_ratio(lp.rb, lp.qb, 1'b0);
      end
      m.kind = (abs_diff(oa, ob) < longint'(tol_cfg)) ? lpi_pkg::KindCoinc
                                                       : lpi_pkg::KindNone;
    end
    return m;
  endfunction

  // Idle gap after a transfer: mostly none or short, now and then long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (burst_mode || r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // A coefficient drawn from full range, small, whole-number, mid-range or extreme values.
  function automatic logic signed [lpi_pkg::DataW-1:0] rand_coef();
    case ($urandom_range(0, 5))
      0, 1: return $urandom;
      2:    return $signed($urandom_range(0, 8)) - 4;
      3:    return ($signed($urandom_range(0, 200)) - 100) <<< lpi_pkg::FracBits;
      4:    return $signed($urandom_range(0, 2000000)) - 1000000;
      default: begin
        case ($urandom_range(0, 3))
          0: return 32'sh7FFF_FFFF;
          1: return 32'sh8000_0000;
          2: return 32'sd0;
          default: return -32'sd1;
        endcase
      end
    endcase
  endfunction

  // Random pair: general lines, parallel or coincident pairs, or vertical lines.
  function automatic line_pair_t rand_pair();
    line_pair_t lp;
    int         k;
    lp.pa = rand_coef(); lp.qa = rand_coef(); lp.ra = rand_coef();
    lp.pb = rand_coef(); lp.qb = rand_coef(); lp.rb = rand_coef();
    case ($urandom_range(0, 4))
      1: begin
        // Scaled copy of the first line, offset sometimes nudged.
        k = $urandom_range(0, 1) ? 1 : ($urandom_range(0, 1) ? 2 : -1);
        lp.pa = ($signed($urandom_range(0, 200)) - 100) <<< 10;
        lp.qa = ($signed($urandom_range(0, 200)) - 100) <<< 10;
        lp.ra = $signed($urandom_range(0, 200000)) - 100000;
        lp.pb = lp.pa * k;
        lp.qb = lp.qa * k;
        lp.rb = lp.ra * k + ($urandom_range(0, 1) ? 0 : $signed($urandom_range(0, 20)) - 10);
      end
      2: begin
        // One or both lines vertical.
        lp.qa = $signed($urandom_range(0, 6)) - 3;
        if ($urandom_range(0, 1)) lp.qb = $signed($urandom_range(0, 6)) - 3;
      end
      default: ;
    endcase
    return lp;
  endfunction

  function automatic line_pair_t make_pair(int pa, int qa, int ra, int pb, int qb, int rb);
    line_pair_t lp;
    lp.pa = pa; lp.qa = qa; lp.ra = ra; lp.pb = pb; lp.qb = qb; lp.rb = rb;
    return lp;
  endfunction

  // Driver: presents queued pairs, with random gaps between transfers.
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) meeting_q.push_back(predict_meeting(cur_pair));
      if (!(start && busy)) begin
        if (gap_left > 0) begin
          gap_left--;
          start <= 1'b0;
        end else if (pair_q.size() > 0) begin
          cur_pair = pair_q.pop_front();
          in_p_a <= cur_pair.pa; in_q_a <= cur_pair.qa; in_r_a <= cur_pair.ra;
          in_p_b <= cur_pair.pb; in_q_b <= cur_pair.qb; in_r_b <= cur_pair.rb;
          start <= 1'b1;
          if ($urandom_range(0, 63) == 0) burst_mode = !burst_mode;
          gap_left = pick_gap();
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: each result transfer is checked against the oldest expectation.
  always @(posedge clk) begin
    meeting_t want;
    if (rst_n && out_valid) begin
      if (meeting_q.size() == 0) begin
        $error("result with no expectation waiting: kind %0d", out_meet_kind);
        error_count++;
      end else begin
        want = meeting_q.pop_front();
        if (out_meet_kind !== want.kind) begin
          $error("meet_kind: expected %0d, actual %0d", want.kind, out_meet_kind);
          error_count++;
        end
        if (out_point_x !== want.x) begin
          $error("point_x: expected %0d, actual %0d", want.x, out_point_x);
          error_count++;
        end
        if (out_point_y !== want.y) begin
          $error("point_y: expected %0d, actual %0d", want.y, out_point_y);
          error_count++;
        end
        if (out_saturated !== want.sat) begin
          $error("saturated: expected %0d, actual %0d", want.sat, out_saturated);
          error_count++;
        end
      end
    end
  end

  // Watchdog: counts cycles without any transfer.
  always @(posedge clk) begin
    if ((start && !busy) || out_valid || cfg_we || !rst_n) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WatchdogLimit) begin
      $display("tb_line_pair_intersection: done, errors");
      $finish;
    end
  end

  // Register write; the predictor copy follows it.
  task automatic write_reg(logic idx, logic [lpi_pkg::CfgW-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    if (idx == lpi_pkg::CfgIdxTol) tol_cfg = val;
    else zero_cfg = val[15:0];
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic wait_idle();
    do @(posedge clk);
    while (pair_q.size() > 0 || start || meeting_q.size() > 0);
  endtask

  // Stimulus and phase sequencing.
  initial begin
    logic [lpi_pkg::CfgW-1:0] tol_set[5];
    logic [lpi_pkg::CfgW-1:0] zero_set[5];
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Directed pairs under reset register values.
    pair_q.push_back(make_pair(65536, 65536, 131072, 65536, -65536, 0));
    pair_q.push_back(make_pair(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
                               32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF));
    pair_q.push_back(make_pair(32'h80000000, 32'h80000000, 32'h80000000,
                               32'h80000000, 32'h80000000, 32'h80000000));
    pair_q.push_back(make_pair(32'h80000000, 32'h7FFFFFFF, 32'h80000000,
                               32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF));
    pair_q.push_back(make_pair(0, 0, 0, 0, 0, 0));
    pair_q.push_back(make_pair(0, 0, 65536, 0, 0, -65536));
    pair_q.push_back(make_pair(65536, 0, 65536, 131072, 1, 131072));
    pair_q.push_back(make_pair(65536, 0, 65536, 65536, -1, 196608));
    pair_q.push_back(make_pair(65536, 65536, 65536, 131072, 131072, 131072));
    pair_q.push_back(make_pair(65536, 65536, 65536, 65536, 65536, 131072));
    pair_q.push_back(make_pair(65536, 0, 65536, 65536, 65536, 0));
    pair_q.push_back(make_pair(0, 65536, 65536, 65536, 0, 65536));
    pair_q.push_back(make_pair(1, 65536, 32'h7FFFFFFF, 0, 65536, 32'h80000000));
    pair_q.push_back(make_pair(1, 32'h7FFFFFFF, 32'h7FFFFFFF, 2, 32'h7FFFFFFF, 0));
    pair_q.push_back(make_pair(32'h7FFFFFFF, 1, 5, 32'h80000000, 2, -5));
    pair_q.push_back(make_pair(0, 65536, 65536, 0, 131072, 0));
    pair_q.push_back(make_pair(-65536, 2, 100, 65536, -3, 100));
    pair_q.push_back(make_pair(3, -1, 7, -3, 1, -7));
    for (int i = 0; i < 170; i++) pair_q.push_back(rand_pair());
    wait_idle();

    // Further settings, the extremes among them.
    tol_set  = '{31'd0, 31'h7FFFFFFF, 31'd65536, 31'd7, $urandom_range(0, 32'h7FFFFFFF)};
    zero_set = '{16'd0, 16'hFFFF, 16'd3, 16'd1, $urandom_range(0, 65535)};
    for (int ph = 0; ph < 5; ph++) begin
      write_reg(lpi_pkg::CfgIdxTol, tol_set[ph]);
      write_reg(lpi_pkg::CfgIdxZero, zero_set[ph] | (ph == 1 ? 31'h7FFF_0000 : 31'd0));
      for (int i = 0; i < 155; i++) pair_q.push_back(rand_pair());
      wait_idle();
    end

    repeat (100) @(posedge clk);
    if (error_count == 0) begin
      $display("tb_line_pair_intersection: done, clean");
    end else begin
      $display("tb_line_pair_intersection: done, errors");
    end
    $finish;
  end

endmodule
